// ===== hw/rtl/mctb_pkg.sv =====
// Shared types and constants for the multi-channel timer bank.
package mctb_pkg;

    localparam int NUM_TIMERS  = 8;
    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = $clog2(NUM_TIMERS + 1);
    localparam int IDX_W       = 3;
    localparam int VAL_W       = 32;
    localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_SET   = 3'd1,
        OP_START = 3'd2,
        OP_STOP  = 3'd3,
        OP_RESET = 3'd4,
        OP_ALLOC = 3'd5,
        OP_READ  = 3'd6
    } t_op;

    typedef enum logic [1:0] {
        KIND_EXPIRY  = 2'd0,
        KIND_GRANT   = 2'd1,
        KIND_REFUSE  = 2'd2,
        KIND_TICKS   = 2'd3
    } t_kind;

    typedef struct packed {
        logic             tick;
        logic             set;
        logic             start;
        logic             stop;
        logic             clr;
        logic [VAL_W-1:0] period;
        logic             one_shot;
    } t_cmd;

endpackage

// ===== hw/rtl/mctb_cell.sv =====
// One timer cell: count, reload, mode, expiry flag and walk token stage.
module mctb_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mctb_pkg::t_cmd i_cmd,
    input  logic           i_sel,
    input  logic           i_active,
    input  logic           i_tok,
    input  logic           i_rest,
    output logic           o_tok,
    output logic           o_rest,
    output logic           o_fire,
    output logic           o_last
);

    logic                       r_en;
    logic                       r_os;
    logic [mctb_pkg::VAL_W-1:0] r_cnt;
    logic [mctb_pkg::VAL_W-1:0] r_rld;
    logic                       r_pend;
    logic                       r_tok;
    logic [mctb_pkg::VAL_W-1:0] cnt_dec;
    logic                       run;
    logic                       hit;

    assign cnt_dec = r_cnt - 1'b1;
    assign run     = i_active & r_en;
    assign hit     = run & (cnt_dec == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en   <= 1'b0;
            r_os   <= 1'b0;
            r_cnt  <= '0;
            r_rld  <= '0;
            r_pend <= 1'b0;
            r_tok  <= 1'b0;
        end else begin
            r_tok <= i_tok;
            if (i_cmd.tick) begin
                r_pend <= hit;
                if (hit) begin
                    r_cnt <= r_rld;
                    if (r_os) begin
                        r_en <= 1'b0;
                    end
                end else if (run) begin
                    r_cnt <= cnt_dec;
                end
            end else if (i_sel) begin
                if (i_cmd.set) begin
                    r_os  <= i_cmd.one_shot;
                    r_cnt <= i_cmd.period;
                    r_rld <= i_cmd.period;
                end
                if (i_cmd.start) begin
                    r_cnt <= r_rld;
                    r_en  <= 1'b1;
                end
                if (i_cmd.stop) begin
                    r_en <= 1'b0;
                end
                if (i_cmd.clr) begin
                    r_en  <= 1'b0;
                    r_cnt <= r_rld;
                end
            end
        end
    end

    assign o_tok  = r_tok;
    assign o_fire = r_tok & r_pend;
    assign o_rest = r_pend | i_rest;
    assign o_last = ~i_rest;

endmodule

// ===== hw/rtl/multi_channel_timer_bank_unit.sv =====
// Set/start/stop/reset are registered in the addressed cell; allocate and read answer in the
// next cycle. A tick updates each allocated running timer on accept, then a token walks the
// cell chain one timer per cycle, emitting registered expiry beats; busy is high meanwhile.
// Other ops are taken every cycle while not busy. Results cannot be stalled.
// Reset (synchronous, active low) clears all timers, the handle count and the tick counter.
// Top level of the multi-channel timer bank.
module multi_channel_timer_bank_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_op,
    input  logic [2:0]  i_timer,
    input  logic [31:0] i_period,
    input  logic        i_one_shot,
    output logic        o_strobe,
    output logic [1:0]  o_kind,
    output logic [2:0]  o_timer_index,
    output logic [31:0] o_value,
    output logic        o_last
);

    localparam int N = mctb_pkg::NUM_TIMERS;

    logic                        acc;
    logic                        valid_t;
    mctb_pkg::t_op               op;
    mctb_pkg::t_cmd              cmd;
    logic [N-1:0]                tok;
    logic [N-1:0]                rest;
    logic [N-1:0]                fire;
    logic [N-1:0]                last;
    logic                        walk_fire;
    logic                        walk_last;
    logic [mctb_pkg::IDX_W-1:0]  walk_idx;

    logic [mctb_pkg::CNT_W-1:0]  r_alloc;
    logic [mctb_pkg::VAL_W-1:0]  r_ticks;
    logic [mctb_pkg::NRES_W-1:0] r_nemit;
    logic                        r_strb;
    mctb_pkg::t_kind             r_kind;
    logic [mctb_pkg::IDX_W-1:0]  r_idx;
    logic [mctb_pkg::VAL_W-1:0]  r_val;
    logic                        r_last;

    assign busy    = |tok;
    assign acc     = start & ~busy;
    assign op      = mctb_pkg::t_op'(i_op);
    assign valid_t = 32'(i_timer) < N;

    always_comb begin
        cmd          = '0;
        cmd.period   = i_period;
        cmd.one_shot = i_one_shot;
        if (acc) begin
            case (op)
                mctb_pkg::OP_TICK:  cmd.tick  = 1'b1;
                mctb_pkg::OP_SET:   cmd.set   = valid_t;
                mctb_pkg::OP_START: cmd.start = valid_t;
                mctb_pkg::OP_STOP:  cmd.stop  = valid_t;
                mctb_pkg::OP_RESET: cmd.clr   = valid_t;
                default:            cmd.tick  = 1'b0;
            endcase
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_cell
        logic tok_in;
        logic rest_in;
        if (k == 0) begin : g_head
            assign tok_in = cmd.tick;
        end else begin : g_body
            assign tok_in = tok[k-1];
        end
        if (k == N - 1) begin : g_tail
            assign rest_in = 1'b0;
        end else begin : g_mid
            assign rest_in = rest[k+1];
        end
        mctb_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_cmd    (cmd),
            .i_sel    (32'(i_timer) == k),
            .i_active (mctb_pkg::CNT_W'(k) < r_alloc),
            .i_tok    (tok_in),
            .i_rest   (rest_in),
            .o_tok    (tok[k]),
            .o_rest   (rest[k]),
            .o_fire   (fire[k]),
            .o_last   (last[k])
        );
    end

    always_comb begin
        walk_idx  = '0;
        walk_last = 1'b0;
        for (int k = 0; k < N; k++) begin
            if (fire[k]) begin
                walk_idx  = mctb_pkg::IDX_W'(k);
                walk_last = last[k];
            end
        end
        walk_fire = (|fire) && (32'(r_nemit) < mctb_pkg::MAX_RESULTS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alloc <= '0;
            r_ticks <= '0;
            r_nemit <= '0;
            r_strb  <= 1'b0;
        end else begin
            r_strb <= 1'b0;
            if (cmd.tick) begin
                r_ticks <= r_ticks + 1'b1;
                r_nemit <= '0;
            end
            if (walk_fire) begin
                r_strb  <= 1'b1;
                r_kind  <= mctb_pkg::KIND_EXPIRY;
                r_idx   <= walk_idx;
                r_val   <= '0;
                r_last  <= walk_last ||
                           (32'(r_nemit) == mctb_pkg::MAX_RESULTS - 1);
                r_nemit <= r_nemit + 1'b1;
            end else if (acc && op == mctb_pkg::OP_ALLOC) begin
                r_strb <= 1'b1;
                r_val  <= '0;
                r_last <= 1'b1;
                if (32'(r_alloc) < N) begin
                    r_kind  <= mctb_pkg::KIND_GRANT;
                    r_idx   <= mctb_pkg::IDX_W'(r_alloc);
                    r_alloc <= r_alloc + 1'b1;
                end else begin
                    r_kind <= mctb_pkg::KIND_REFUSE;
                    r_idx  <= '0;
                end
            end else if (acc && op == mctb_pkg::OP_READ) begin
                r_strb <= 1'b1;
                r_kind <= mctb_pkg::KIND_TICKS;
                r_idx  <= '0;
                r_val  <= r_ticks;
                r_last <= 1'b1;
            end
        end
    end

    assign o_strobe      = r_strb;
    assign o_kind        = r_kind;
    assign o_timer_index = r_idx;
    assign o_value       = r_val;
    assign o_last        = r_last;

    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(tok))
        else $error("more than one walk token in the cell chain");

    a_alloc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_alloc) <= N)
        else $error("handle count beyond bank size");

    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && op == mctb_pkg::OP_TICK |=> busy)
        else $error("tick accepted but walk not started");

    a_expiry_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_kind == mctb_pkg::KIND_EXPIRY |-> $past(busy))
        else $error("expiry beat outside a tick walk");

endmodule

// ===== dv/mctb_checker.sv =====
// Checker for the timer bank: predicts result beats from accepted commands and compares them.
`timescale 1ns / 1ps
module mctb_checker
    import mctb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [2:0]  i_op,
    input  logic [2:0]  i_timer,
    input  logic [31:0] i_period,
    input  logic        i_one_shot,
    input  logic        i_strobe,
    input  logic [1:0]  i_kind,
    input  logic [2:0]  i_timer_index,
    input  logic [31:0] i_value,
    input  logic        i_last,
    output int          o_errors,
    output int          o_pending
);

    typedef struct {
        t_kind             kind;
        logic [IDX_W-1:0]  idx;
        logic [VAL_W-1:0]  value;
        logic              last;
    } t_beat;

    logic              armed     [NUM_TIMERS];
    logic              single    [NUM_TIMERS];
    logic [VAL_W-1:0]  remain    [NUM_TIMERS];
    logic [VAL_W-1:0]  reload_val[NUM_TIMERS];
    int unsigned       handles;
    logic [VAL_W-1:0]  tick_total;
    t_beat             expected_beats[$];
    t_beat             want;

    function automatic t_beat make_beat(t_kind k, logic [IDX_W-1:0] idx,
                                        logic [VAL_W-1:0] val, logic fin);
        t_beat b;
        b.kind  = k;
        b.idx   = idx;
        b.value = val;
        b.last  = fin;
        return b;
    endfunction

    task automatic predict_command(input logic [2:0] op, input logic [2:0] tmr,
                                   input logic [31:0] per, input logic os);
        int               n;
        int               j;
        logic [IDX_W-1:0] fired[MAX_RESULTS];
        logic             tmr_ok;
        tmr_ok = int'(tmr) < NUM_TIMERS;
        n = 0;
        case (op)
            OP_TICK: begin
                tick_total = tick_total + 1;
                for (j = 0; j < NUM_TIMERS && j < int'(handles); j++) begin
                    if (armed[j]) begin
                        remain[j] = remain[j] - 1;
                        if (remain[j] == '0) begin
                            if (single[j])
                                armed[j] = 1'b0;
                            remain[j] = reload_val[j];
                            if (n < MAX_RESULTS) begin
                                fired[n] = IDX_W'(j);
                                n++;
                            end
                        end
                    end
                end
                for (j = 0; j < n; j++)
                    expected_beats.push_back(make_beat(KIND_EXPIRY, fired[j], '0, j == n - 1));
            end
            OP_SET: begin
                if (tmr_ok) begin
                    single[tmr]     = os;
                    remain[tmr]     = per;
                    reload_val[tmr] = per;
                end
            end
            OP_START: begin
                if (tmr_ok) begin
                    remain[tmr] = reload_val[tmr];
                    armed[tmr]  = 1'b1;
                end
            end
            OP_STOP: begin
                if (tmr_ok)
                    armed[tmr] = 1'b0;
            end
            OP_RESET: begin
                if (tmr_ok) begin
                    armed[tmr]  = 1'b0;
                    remain[tmr] = reload_val[tmr];
                end
            end
            OP_ALLOC: begin
                if (handles < NUM_TIMERS) begin
                    expected_beats.push_back(make_beat(KIND_GRANT, IDX_W'(handles), '0, 1'b1));
                    handles++;
                end else begin
                    expected_beats.push_back(make_beat(KIND_REFUSE, '0, '0, 1'b1));
                end
            end
            OP_READ: begin
                expected_beats.push_back(make_beat(KIND_TICKS, '0, tick_total, 1'b1));
            end
            default: begin
            end
        endcase
    endtask

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_TIMERS; k++) begin
                armed[k]      = 1'b0;
                single[k]     = 1'b0;
                remain[k]     = '0;
                reload_val[k] = '0;
            end
            handles    = 0;
            tick_total = '0;
            expected_beats.delete();
        end else begin
            // compare first: a beat at this edge always belongs to an older command
            if (i_strobe) begin
                if (expected_beats.size() == 0) begin
                    if (o_errors < 10)
                        $display("%0t: unexpected beat kind=%0d idx=%0d value=%h last=%b",
                                 $realtime, i_kind, i_timer_index, i_value, i_last);
                    o_errors++;
                end else begin
                    want = expected_beats.pop_front();
                    if (i_kind !== want.kind || i_timer_index !== want.idx ||
                        i_value !== want.value || i_last !== want.last) begin
                        if (o_errors < 10)
                            $display("%0t: mismatch exp %0d/%0d/%h/%b got %0d/%0d/%h/%b",
                                     $realtime, want.kind, want.idx, want.value, want.last,
                                     i_kind, i_timer_index, i_value, i_last);
                        o_errors++;
                    end
                end
            end
            if (i_start && !i_busy)
                predict_command(i_op, i_timer, i_period, i_one_shot);
        end
        o_pending <= expected_beats.size();
    end

endmodule

// ===== dv/tb_multi_channel_timer_bank_unit.sv =====
// Testbench top for the timer bank: directed and random commands, checker beside the block.
`timescale 1ns / 1ps
module tb_multi_channel_timer_bank_unit;
    import mctb_pkg::*;

    localparam logic [2:0] OP_UNUSED = 3'd7;
    localparam int         NUM_CMDS  = 220;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_op;
    logic [2:0]  i_timer;
    logic [31:0] i_period;
    logic        i_one_shot;
    logic        o_strobe;
    logic [1:0]  o_kind;
    logic [2:0]  o_timer_index;
    logic [31:0] o_value;
    logic        o_last;
    int          errors;
    int          pending;
    int          idle_pct;
    int          cmds_sent;

    multi_channel_timer_bank_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_op          (i_op),
        .i_timer       (i_timer),
        .i_period      (i_period),
        .i_one_shot    (i_one_shot),
        .o_strobe      (o_strobe),
        .o_kind        (o_kind),
        .o_timer_index (o_timer_index),
        .o_value       (o_value),
        .o_last        (o_last)
    );

    mctb_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_op          (i_op),
        .i_timer       (i_timer),
        .i_period      (i_period),
        .i_one_shot    (i_one_shot),
        .i_strobe      (o_strobe),
        .i_kind        (o_kind),
        .i_timer_index (o_timer_index),
        .i_value       (o_value),
        .i_last        (o_last),
        .o_errors      (errors),
        .o_pending     (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // called just after a rising edge; returns at the edge where the command is taken
    task automatic issue_cmd(input logic [2:0] op, input logic [2:0] tmr,
                             input logic [31:0] per, input logic os);
        while ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        start      <= 1'b1;
        i_op       <= op;
        i_timer    <= tmr;
        i_period   <= per;
        i_one_shot <= os;
        forever begin
            @(posedge i_clk);
            if (!busy)
                break;
        end
    endtask

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        logic [2:0]  op;
        logic [31:0] per;
        int          pick;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_op       = OP_TICK;
        i_timer    = '0;
        i_period   = '0;
        i_one_shot = 1'b0;
        idle_pct   = 31;
        cmds_sent  = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: unallocated timers, period one, zero and max, one-shot, full bank
        issue_cmd(OP_READ,  3'd0, 32'h0, 1'b0);
        issue_cmd(OP_TICK,  3'd0, 32'h0, 1'b0);
        issue_cmd(OP_ALLOC, 3'd0, 32'h0, 1'b0);
        issue_cmd(OP_ALLOC, 3'd0, 32'h0, 1'b0);
        issue_cmd(OP_SET,   3'd0, 32'd1, 1'b0);
        issue_cmd(OP_SET,   3'd1, 32'd2, 1'b1);
        issue_cmd(OP_SET,   3'd5, 32'd1, 1'b1);
        issue_cmd(OP_START, 3'd0, 32'h0, 1'b0);
        issue_cmd(OP_START, 3'd1, 32'h0, 1'b0);
        issue_cmd(OP_START, 3'd5, 32'h0, 1'b0);
        issue_cmd(OP_TICK,  3'd7, 32'hFFFF_FFFF, 1'b1);
        issue_cmd(OP_TICK,  3'd0, 32'h0, 1'b0);
        issue_cmd(OP_ALLOC, 3'd0, 32'h0, 1'b0);
        issue_cmd(OP_SET,   3'd2, 32'h0, 1'b0);
        issue_cmd(OP_START, 3'd2, 32'h0, 1'b0);
        issue_cmd(OP_SET,   3'd7, 32'hFFFF_FFFF, 1'b1);
        issue_cmd(OP_START, 3'd7, 32'h0, 1'b0);
        issue_cmd(OP_TICK,  3'd0, 32'h0, 1'b0);
        issue_cmd(OP_STOP,  3'd0, 32'h0, 1'b0);
        issue_cmd(OP_RESET, 3'd1, 32'h0, 1'b0);
        issue_cmd(OP_UNUSED, 3'd7, 32'hFFFF_FFFF, 1'b1);
        repeat (6) issue_cmd(OP_ALLOC, 3'd0, 32'h0, 1'b0);
        issue_cmd(OP_TICK,  3'd0, 32'h0, 1'b0);
        issue_cmd(OP_READ,  3'd0, 32'h0, 1'b0);

        // random: mostly small periods so timers expire often
        while (cmds_sent < NUM_CMDS) begin
            idle_pct = (cmds_sent < NUM_CMDS / 3) ? 31 :
                       (cmds_sent < 2 * NUM_CMDS / 3) ? 67 : 0;
            pick = $urandom_range(99);
            if (pick < 38)
                op = OP_TICK;
            else if (pick < 53)
                op = OP_SET;
            else if (pick < 68)
                op = OP_START;
            else if (pick < 73)
                op = OP_STOP;
            else if (pick < 78)
                op = OP_RESET;
            else if (pick < 83)
                op = OP_ALLOC;
            else if (pick < 93)
                op = OP_READ;
            else
                op = OP_UNUSED;
            pick = $urandom_range(99);
            if (pick < 70)
                per = $urandom_range(6, 1);
            else if (pick < 80)
                per = 32'h0;
            else if (pick < 88)
                per = 32'hFFFF_FFFF;
            else
                per = $urandom;
            issue_cmd(op, 3'($urandom_range(7)), per, 1'($urandom_range(1)));
            cmds_sent++;
        end
        @(negedge i_clk);
        start <= 1'b0;

        wait (pending == 0);
        repeat (NUM_TIMERS + 4) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/mctb_pkg.sv
hw/rtl/mctb_cell.sv
hw/rtl/multi_channel_timer_bank_unit.sv
dv/mctb_checker.sv
dv/tb_multi_channel_timer_bank_unit.sv
